### hdl/ipd_pkg.sv
package ipd_pkg;

  localparam int COUNT_BITS = 24;
  localparam int LEN_W      = 24;
  localparam int LIMIT_W    = 24;
  localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  localparam int WIN_LEN    = 19;
  localparam int CHAIN_LEN  = WIN_LEN - 1;
  localparam int END_LEN    = 10;
  localparam int HDR_LEN    = 9;
  localparam int END_OFS    = WIN_LEN - END_LEN + 1;

  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [PADDR_W-3:0] REG_PAYLOAD_LIMIT = '0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET       = '1;

  localparam logic [7:0] END_PAT [END_LEN] = '{
    8'h0d, 8'h0a, 8'h43, 8'h4c, 8'h4f, 8'h53, 8'h45, 8'h44, 8'h0d, 8'h0a
  };
  localparam logic [7:0] HDR_PAT [HDR_LEN] = '{
    8'h0d, 8'h0a, 8'h0d, 8'h0a, 8'h2b, 8'h49, 8'h50, 8'h44, 8'h2c
  };
  localparam logic [7:0] COLON_CHR = 8'h3a;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [7:0]       payload_byte;
    logic [1:0]       status_code;
    logic [LEN_W-1:0] payload_length;
    logic             last_result;
  } out_item_t;

  typedef struct packed {
    logic [END_LEN-1:0] end_hit;
    logic [HDR_LEN-1:0] hdr_hit;
    logic               colon;
  } chr_flags_t;

  typedef struct packed {
    logic shift;
    logic kill;
  } cell_ctl_t;

  function automatic chr_flags_t classify(input logic [7:0] dat, input logic vld);
    chr_flags_t f;
    for (int i = 0; i < END_LEN; i++) begin
      f.end_hit[i] = vld && (dat == END_PAT[i]);
    end
    for (int i = 0; i < HDR_LEN; i++) begin
      f.hdr_hit[i] = vld && (dat == HDR_PAT[i]);
    end
    f.colon = vld && (dat == COLON_CHR);
    return f;
  endfunction

endpackage

### hdl/ipd_header_strip_deframer.sv
// Payload extractor for a received byte stream. Bytes enter one per cycle
// through an 18-cell shift chain that, with the incoming byte, forms a
// 19-byte lookahead window; the oldest byte is decided as the window fills,
// so streaming runs at one byte per clock, with one result at most per byte,
// while the result buffer has room. After the byte flagged last, the block
// checks for the end delimiter, then, unless the chain was cleared, shifts
// it out while the result buffer has room (each shift giving at most one
// payload byte), sees the chain empty and issues the status result once the
// buffer has room; no new byte is taken before that. A two-entry result
// buffer lets input continue while one result waits. If the status reports
// a missing end, the payload bytes already delivered for that buffer must
// be discarded. payload_limit (reg 0) may be written only while the block
// is idle.
module ipd_header_strip_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ipd_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ipd_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ipd_pkg::PADDR_W-1:0]    paddr,
  input  logic [ipd_pkg::PDATA_W-1:0]    pwdata,
  output logic [ipd_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import ipd_pkg::*;

  localparam logic [1:0] S_RUN    = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_FLUSH  = 2'd2;
  localparam logic [1:0] S_STATUS = 2'd3;

  localparam logic [1:0] MODE_COPY   = 2'd0;
  localparam logic [1:0] MODE_SKIP   = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;
  localparam logic [1:0] MODE_DONE   = 2'd3;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NO_END   = 2'd1;
  localparam logic [1:0] STS_OVERFLOW = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  logic [LIMIT_W-1:0]    limit_r;
  logic [1:0]            state_r, state_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [COUNT_BITS-1:0] emitted_count_r, emitted_count_nxt;
  logic                  end_found_r, end_found_nxt;
  logic                  overrun_r, overrun_nxt;

  wire  [7:0]            w_data  [WIN_LEN];
  wire  [WIN_LEN-1:0]    w_valid;
  wire  chr_flags_t      w_flags [WIN_LEN];
  logic [CHAIN_LEN-1:0]  chain_valid;
  cell_ctl_t             cell_ctl [CHAIN_LEN];

  logic                  tail_valid;
  logic                  in_accept;
  logic [END_OFS-1:0]    end_at;
  logic                  hdr_at0;
  logic                  hdr_blocked;
  logic                  limit_hit;
  logic                  shift_en;
  logic                  decide;
  logic                  kill_all;
  logic                  kill_head;
  logic                  push;
  out_item_t             push_item;
  logic                  res_full;
  logic                  cfg_write;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1:2] == REG_PAYLOAD_LIMIT);
  assign prdata    = (paddr[PADDR_W-1:2] == REG_PAYLOAD_LIMIT) ?
                     PDATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_write) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  // window: chain cells plus the incoming byte at the tail
  assign in_ready   = (state_r == S_RUN) && !res_full;
  assign in_accept  = in_valid && in_ready;
  assign tail_valid = (state_r == S_RUN) && in_valid && (mode_r != MODE_DONE);

  assign w_data[CHAIN_LEN]  = in_data.data_byte;
  assign w_valid[CHAIN_LEN] = tail_valid;
  assign w_flags[CHAIN_LEN] = classify(in_data.data_byte, tail_valid);
  assign chain_valid        = w_valid[CHAIN_LEN-1:0];

  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
    ipd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl[k]),
      .nxt_data   (w_data[k+1]),
      .nxt_valid  (w_valid[k+1]),
      .cell_data  (w_data[k]),
      .cell_valid (w_valid[k]),
      .flags      (w_flags[k])
    );
  end

  always_comb begin
    for (int k = 0; k < CHAIN_LEN; k++) begin
      cell_ctl[k].shift = shift_en;
      cell_ctl[k].kill  = kill_all || (kill_head && (k < HDR_LEN - 1));
    end
  end

  // pattern detection over the window
  always_comb begin
    for (int k = 0; k < END_OFS; k++) begin
      end_at[k] = 1'b1;
      for (int i = 0; i < END_LEN; i++) begin
        end_at[k] = end_at[k] && w_flags[k+i].end_hit[i];
      end
    end
    hdr_at0 = w_valid[HDR_LEN];
    for (int i = 0; i < HDR_LEN; i++) begin
      hdr_at0 = hdr_at0 && w_flags[i].hdr_hit[i];
    end
  end

  assign hdr_blocked = |end_at[HDR_LEN:1];
  assign limit_hit   = (CMP_W'(emitted_count_r) >= CMP_W'(limit_r)) || (&emitted_count_r);

  // control
  always_comb begin
    state_nxt         = state_r;
    mode_nxt          = mode_r;
    emitted_count_nxt = emitted_count_r;
    end_found_nxt     = end_found_r;
    overrun_nxt       = overrun_r;
    shift_en          = 1'b0;
    decide            = 1'b0;
    kill_all          = 1'b0;
    kill_head         = 1'b0;
    push              = 1'b0;
    push_item         = '0;

    case (state_r)
      S_RUN: begin
        shift_en = in_accept;
        decide   = in_accept && chain_valid[0];
        if (in_accept && in_data.last_byte) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!end_found_r && !(|end_at)) begin
          kill_all = 1'b1;
        end
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        if (!(|chain_valid)) begin
          state_nxt = S_STATUS;
        end else if (!res_full) begin
          shift_en = 1'b1;
          decide   = chain_valid[0];
        end
      end
      S_STATUS: begin
        if (!res_full) begin
          push                     = 1'b1;
          push_item.result_kind    = KIND_STATUS;
          push_item.status_code    = !end_found_r ? STS_NO_END :
                                     (overrun_r ? STS_OVERFLOW : STS_OK);
          push_item.payload_length = LEN_W'(emitted_count_r);
          push_item.last_result    = 1'b1;
          mode_nxt                 = MODE_COPY;
          emitted_count_nxt        = '0;
          end_found_nxt            = 1'b0;
          overrun_nxt              = 1'b0;
          state_nxt                = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase

    if (decide) begin
      if (mode_r == MODE_DONE) begin
        kill_all = 1'b1;
      end else if (end_at[0]) begin
        end_found_nxt = 1'b1;
        mode_nxt      = MODE_DONE;
        kill_all      = 1'b1;
      end else if (mode_r == MODE_SKIP) begin
        if (w_flags[0].colon) begin
          mode_nxt = MODE_COPY;
        end
      end else if (mode_r == MODE_SEARCH) begin
        mode_nxt = MODE_SEARCH;
      end else if (limit_hit) begin
        overrun_nxt = 1'b1;
        mode_nxt    = MODE_SEARCH;
      end else if (hdr_at0 && !hdr_blocked) begin
        mode_nxt  = MODE_SKIP;
        kill_head = 1'b1;
      end else begin
        push                   = 1'b1;
        push_item.result_kind  = KIND_DATA;
        push_item.payload_byte = w_data[0];
        emitted_count_nxt      = emitted_count_r + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_RUN;
      mode_r          <= MODE_COPY;
      emitted_count_r <= '0;
      end_found_r     <= 1'b0;
      overrun_r       <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      mode_r          <= mode_nxt;
      emitted_count_r <= emitted_count_nxt;
      end_found_r     <= end_found_nxt;
      overrun_r       <= overrun_nxt;
    end
  end

  ipd_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (res_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // while streaming, held bytes always sit against the tail of the chain
  a_tail_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |->
      ((chain_valid[CHAIN_LEN-2:0] & ~chain_valid[CHAIN_LEN-1:1]) == '0))
    else $error("chain valid bits not tail aligned");

  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DONE) |-> (chain_valid == '0))
    else $error("bytes held after end delimiter");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !res_full)
    else $error("result pushed into full buffer");

  a_status_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STATUS) |-> (chain_valid == '0))
    else $error("status issued with bytes left in chain");
`endif

endmodule

### hdl/ipd_cell.sv
module ipd_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ipd_pkg::cell_ctl_t ctl,
  input  logic [7:0]         nxt_data,
  input  logic               nxt_valid,
  output logic [7:0]         cell_data,
  output logic               cell_valid,
  output ipd_pkg::chr_flags_t flags
);
  import ipd_pkg::*;

  logic [7:0] data_r;
  logic       valid_r;
  logic       valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.kill) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt = nxt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= nxt_data;
    end
  end

  assign cell_data  = data_r;
  assign cell_valid = valid_r;
  assign flags      = classify(data_r, valid_r);

endmodule

### hdl/ipd_res_fifo.sv
module ipd_res_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ipd_pkg::out_item_t  push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output ipd_pkg::out_item_t  out_data
);
  import ipd_pkg::*;

  out_item_t  entry0_r, entry0_nxt;
  out_item_t  entry1_r, entry1_nxt;
  logic [1:0] count_r, count_nxt;
  logic [1:0] level;
  logic       pop;

  assign pop = out_valid && out_ready;

  always_comb begin
    entry0_nxt = entry0_r;
    entry1_nxt = entry1_r;
    level      = count_r;
    if (pop) begin
      entry0_nxt = entry1_r;
      level      = count_r - 2'd1;
    end
    count_nxt = level;
    if (push) begin
      if (level == 2'd0) begin
        entry0_nxt = push_item;
      end else begin
        entry1_nxt = push_item;
      end
      count_nxt = level + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry0_r <= entry0_nxt;
    entry1_r <= entry1_nxt;
  end

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = entry0_r;

endmodule
